>>> src/rfa_pkg.sv
// Shared types and constants for the register file ALU with flags.
// Used by rfa_regfile and register_file_alu_with_flags_unit; no dependencies.
package rfa_pkg;

  // Default register count and reset constants
  localparam int unsigned REG_COUNT_DEF = 8;
  localparam int unsigned SP_INDEX      = 4;
  localparam logic [15:0] SP_RESET      = 16'hFFFE;
  localparam logic [15:0] WORD_ONES     = 16'hFFFF;
  localparam logic [15:0] SIGN_MASK     = 16'h8000;

  // Operation codes carried on the cmd field
  typedef enum logic [2:0] {
    OP_MOV   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_CMP   = 3'd3,
    OP_INC   = 3'd4,
    OP_DEC   = 3'd5,
    OP_RESET = 3'd6,
    OP_READ  = 3'd7
  } op_t;

  // Control from the ALU stage to the register file
  typedef struct packed {
    logic rd_en;   // capture both read ports this cycle
    logic wr_en;   // write wr_data to wr_addr
    logic clear;   // return every register to its reset value
  } rf_ctl_t;

endpackage

>>> src/rfa_regfile.sv
// Register storage: synchronous memory with two read ports and one write port,
// per-entry valid bits for the clear operation and write-to-read forwarding.
// Depends on rfa_pkg.
module rfa_regfile #(
  parameter int unsigned REG_COUNT = rfa_pkg::REG_COUNT_DEF,
  parameter int unsigned IW        = $clog2(REG_COUNT)
) (
  input  logic            clk,
  input  logic            rst,
  input  rfa_pkg::rf_ctl_t ctl,
  input  logic [IW-1:0]   rd_a_addr,
  input  logic [IW-1:0]   rd_b_addr,
  input  logic [IW-1:0]   wr_addr,
  input  logic [15:0]     wr_data,
  output logic [15:0]     rd_a_data,
  output logic [15:0]     rd_b_data
);

  localparam int unsigned XW = IW + 3;

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [15:0]          q_a;
  logic [15:0]          q_b;
  logic [IW-1:0]        qa_addr;
  logic [IW-1:0]        qb_addr;
  logic                 fwd_en;
  logic [IW-1:0]        fwd_addr;
  logic [15:0]          fwd_data;
  logic [15:0]          rst_a;
  logic [15:0]          rst_b;

  // Memory write port and registered read ports
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q_a     <= mem[rd_a_addr];
      q_b     <= mem[rd_b_addr];
      qa_addr <= rd_a_addr;
      qb_addr <= rd_b_addr;
    end
  end

  // Valid bits: an entry not written since the last clear reads as its reset value
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Last write, forwarded over a read taken at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else if (ctl.wr_en || ctl.clear) begin
      fwd_en <= ctl.wr_en;
    end
    if (ctl.wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // Reset value: stack pointer or zero
  assign rst_a = ({3'b000, qa_addr} == XW'(rfa_pkg::SP_INDEX)) ? rfa_pkg::SP_RESET : '0;
  assign rst_b = ({3'b000, qb_addr} == XW'(rfa_pkg::SP_INDEX)) ? rfa_pkg::SP_RESET : '0;

  always_comb begin
    if (fwd_en && fwd_addr == qa_addr) begin
      rd_a_data = fwd_data;
    end else if (!vld[qa_addr]) begin
      rd_a_data = rst_a;
    end else begin
      rd_a_data = q_a;
    end
    if (fwd_en && fwd_addr == qb_addr) begin
      rd_b_data = fwd_data;
    end else if (!vld[qb_addr]) begin
      rd_b_data = rst_b;
    end else begin
      rd_b_data = q_b;
    end
  end

`ifndef SYNTHESIS
  // Clear and write are never issued together
  a_clear_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.clear && ctl.wr_en))
    else $error("register clear and write in the same cycle");

  // A write marks its entry valid
  a_wr_sets_vld: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> vld[$past(wr_addr)])
    else $error("written entry not marked valid");

  // A clear leaves every entry invalid
  a_clear_vld: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> vld == '0)
    else $error("valid bits not cleared");
`endif

endmodule

>>> src/register_file_alu_with_flags_unit.sv
// Top level: register file ALU with zero, carry and sign flags.
// Depends on rfa_pkg and rfa_regfile.
//
// One operation per item, one item per cycle sustained while res_stall is low. An
// item accepted at a clock edge reads both register file ports at that edge; in
// the next cycle the ALU stage computes the result, and as the item leaves the
// ALU stage it writes the destination register and the flags and loads the
// output register, which offers the result until it is taken. The rate is set
// by the single ALU stage behind the registered memory read; a write from the
// item just ahead is forwarded into the next item's operands. RESET clears the
// whole register file through per-register valid bits. Indexes at or above
// REG_COUNT read as zero and are not written. op_stall rises only while the
// ALU stage holds an item that the output register cannot take.
module register_file_alu_with_flags_unit #(
  parameter int unsigned REG_COUNT = rfa_pkg::REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_stall,
  input  logic [2:0]  cmd,
  input  logic [2:0]  dst_index,
  input  logic        src_is_register,
  input  logic [2:0]  src_index,
  input  logic [15:0] immediate,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] value,
  output logic        zero_flag,
  output logic        carry_flag,
  output logic        sign_flag
);

  localparam int unsigned IW = $clog2(REG_COUNT);
  localparam int unsigned XW = IW + 3;

  logic             op_acc;
  logic [XW-1:0]    dst_wide;
  logic [XW-1:0]    src_wide;
  rfa_pkg::rf_ctl_t rf_ctl;
  logic [15:0]      rd_a_data;
  logic [15:0]      rd_b_data;

  // ALU stage registers
  logic             s1_valid;
  rfa_pkg::op_t     s1_cmd;
  logic [IW-1:0]    s1_dst;
  logic             s1_dst_ok;
  logic             s1_dst_sp;
  logic             s1_src_reg;
  logic             s1_src_ok;
  logic [15:0]      s1_imm;
  logic             s1_adv;

  // Architectural flags
  logic             zero_bit;
  logic             carry_bit;
  logic             sign_bit;

  // ALU signals
  logic [15:0]      opa;
  logic [15:0]      opb;
  logic [16:0]      sum;
  logic [16:0]      diff;
  logic [15:0]      shown;
  logic             wr;
  logic             clr;
  logic             zero_next;
  logic             carry_next;
  logic             sign_next;

  // Input handshake
  assign s1_adv   = s1_valid && (!res_valid || !res_stall);
  assign op_stall = s1_valid && !s1_adv;
  assign op_acc   = op_valid && !op_stall;

  assign dst_wide = {{IW{1'b0}}, dst_index};
  assign src_wide = {{IW{1'b0}}, src_index};

  // Capture the item into the ALU stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (op_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (op_acc) begin
      s1_cmd     <= rfa_pkg::op_t'(cmd);
      s1_dst     <= dst_wide[IW-1:0];
      s1_dst_ok  <= dst_wide < XW'(REG_COUNT);
      s1_dst_sp  <= dst_wide == XW'(rfa_pkg::SP_INDEX);
      s1_src_reg <= src_is_register;
      s1_src_ok  <= src_wide < XW'(REG_COUNT);
      s1_imm     <= immediate;
    end
  end

  // Register file
  assign rf_ctl.rd_en = op_acc;
  assign rf_ctl.wr_en = s1_adv && wr && s1_dst_ok;
  assign rf_ctl.clear = s1_adv && clr;

  rfa_regfile #(
    .REG_COUNT (REG_COUNT),
    .IW        (IW)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rf_ctl),
    .rd_a_addr (dst_wide[IW-1:0]),
    .rd_b_addr (src_wide[IW-1:0]),
    .wr_addr   (s1_dst),
    .wr_data   (shown),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Operands
  assign opa  = s1_dst_ok ? rd_a_data : '0;
  assign opb  = s1_src_reg ? (s1_src_ok ? rd_b_data : '0) : s1_imm;
  assign sum  = {1'b0, opa} + {1'b0, opb};
  assign diff = {1'b0, opa} - {1'b0, opb};

  // ALU and flag update
  always_comb begin
    shown      = opa;
    wr         = 1'b0;
    clr        = 1'b0;
    carry_next = carry_bit;
    case (s1_cmd)
      rfa_pkg::OP_MOV: begin
        shown = opb;
        wr    = 1'b1;
      end
      rfa_pkg::OP_ADD: begin
        shown      = sum[15:0];
        carry_next = sum[16];
        wr         = 1'b1;
      end
      rfa_pkg::OP_SUB: begin
        shown      = diff[15:0];
        carry_next = diff[16];
        wr         = 1'b1;
      end
      rfa_pkg::OP_CMP: begin
        shown      = diff[15:0];
        carry_next = diff[16];
      end
      rfa_pkg::OP_INC: begin
        shown = opa + 16'd1;
        wr    = 1'b1;
      end
      rfa_pkg::OP_DEC: begin
        shown = opa + rfa_pkg::WORD_ONES;
        wr    = 1'b1;
      end
      rfa_pkg::OP_RESET: begin
        shown      = (s1_dst_ok && s1_dst_sp) ? rfa_pkg::SP_RESET : '0;
        clr        = 1'b1;
        carry_next = 1'b0;
      end
      default: begin
        shown = opa;
      end
    endcase
    // Zero and sign follow the result except on RESET and register read
    if (s1_cmd == rfa_pkg::OP_RESET) begin
      zero_next = 1'b0;
      sign_next = 1'b0;
    end else if (s1_cmd == rfa_pkg::OP_READ) begin
      zero_next = zero_bit;
      sign_next = sign_bit;
    end else begin
      zero_next = shown == '0;
      sign_next = (shown & rfa_pkg::SIGN_MASK) != '0;
    end
  end

  // Flag state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_bit  <= 1'b0;
      carry_bit <= 1'b0;
      sign_bit  <= 1'b0;
    end else if (s1_adv) begin
      zero_bit  <= zero_next;
      carry_bit <= carry_next;
      sign_bit  <= sign_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_adv) begin
      value      <= shown;
      zero_flag  <= zero_next;
      carry_flag <= carry_next;
      sign_flag  <= sign_next;
    end
  end

`ifndef SYNTHESIS
  // Writes happen only as an in-range item leaves the ALU stage
  a_wr_gated: assert property (@(posedge clk) disable iff (rst)
    rf_ctl.wr_en |-> s1_adv && s1_dst_ok)
    else $error("register write outside an ALU stage advance");

  // An accepted item occupies the ALU stage next cycle
  a_acc_fills: assert property (@(posedge clk) disable iff (rst)
    op_acc |=> s1_valid)
    else $error("accepted item lost before the ALU stage");

  // An item leaving the ALU stage is offered at the output
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("result not offered after ALU stage");

  // RESET clears every flag
  a_reset_flags: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_cmd == rfa_pkg::OP_RESET |=> !zero_bit && !carry_bit && !sign_bit)
    else $error("flags not cleared by RESET");

  // INC and DEC keep carry
  a_incdec_carry: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_cmd == rfa_pkg::OP_INC || s1_cmd == rfa_pkg::OP_DEC)
    |=> carry_bit == $past(carry_bit))
    else $error("carry changed by INC or DEC");
`endif

endmodule
